FILE: hdl/eip_pkg.sv
// Shared types and constants for the Ethernet/IPv4/TCP-UDP header parser.
package eip_pkg;

    localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
    localparam logic [7:0]  ETH_HDR_LEN    = 8'd14;
    localparam logic [7:0]  IP_MIN_HDR     = 8'd20;
    localparam logic [7:0]  TCP_HDR_LEN    = 8'd20;
    localparam logic [7:0]  UDP_HDR_LEN    = 8'd8;
    localparam logic [7:0]  PROTO_TCP      = 8'd6;
    localparam logic [7:0]  PROTO_UDP      = 8'd17;
    localparam logic [3:0]  IP_VERSION_4   = 4'd4;
    localparam logic [6:0]  INDEX_MAX      = 7'd127;

    localparam logic [6:0]  OFS_ETHERTYPE_HI = 7'd12;
    localparam logic [6:0]  OFS_ETHERTYPE_LO = 7'd13;
    localparam logic [6:0]  OFS_VERSION_IHL  = 7'd14;
    localparam logic [6:0]  OFS_TOTLEN_HI    = 7'd16;
    localparam logic [6:0]  OFS_TOTLEN_LO    = 7'd17;
    localparam logic [6:0]  OFS_PROTOCOL     = 7'd23;
    localparam logic [6:0]  OFS_SRC_FIRST    = 7'd26;
    localparam logic [6:0]  OFS_SRC_LAST     = 7'd29;
    localparam logic [6:0]  OFS_DST_FIRST    = 7'd30;
    localparam logic [6:0]  OFS_DST_LAST     = 7'd33;
    localparam logic [6:0]  OFS_TRANSPORT    = 7'd34;
    localparam logic [7:0]  OFS_TCP_FLAGS    = 8'd13;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       last_byte;
    } in_t;

    typedef struct packed {
        logic        header_ok;
        logic [31:0] source_address;
        logic [31:0] dest_address;
        logic [7:0]  ip_protocol;
        logic [15:0] ip_total_length;
        logic [15:0] source_port;
        logic [15:0] dest_port;
        logic [7:0]  tcp_flag_bits;
    } out_t;

    typedef struct packed {
        logic [15:0] ether_type;
        logic [7:0]  version_ihl;
        logic [7:0]  protocol;
        logic [15:0] total_length;
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
        logic [15:0] transport_src;
        logic [15:0] transport_dst;
        logic [7:0]  flags;
    } hdr_t;

endpackage

FILE: hdl/eip_check.sv
// Length, EtherType, version and header-length checks that build one parse result.
module eip_check (
    input  eip_pkg::hdr_t hdr,
    input  logic [6:0]    frame_len,
    output eip_pkg::out_t result
);

    logic [7:0] len_ext;
    logic [7:0] hdr_len;
    logic [7:0] ip_len;
    logic [7:0] l4_len;
    logic       is_tcp;
    logic       is_udp;
    logic       ok;

    always_comb
    begin
        len_ext = {1'b0, frame_len};
        hdr_len = {2'b00, hdr.version_ihl[3:0], 2'b00};
        ip_len  = len_ext - eip_pkg::ETH_HDR_LEN;
        l4_len  = ip_len - hdr_len;
        is_tcp  = (hdr.protocol == eip_pkg::PROTO_TCP);
        is_udp  = (hdr.protocol == eip_pkg::PROTO_UDP);

        ok = (len_ext >= eip_pkg::ETH_HDR_LEN)
            && (hdr.ether_type == eip_pkg::ETHERTYPE_IPV4)
            && (ip_len >= eip_pkg::IP_MIN_HDR)
            && (hdr.version_ihl[7:4] == eip_pkg::IP_VERSION_4)
            && (hdr_len >= eip_pkg::IP_MIN_HDR)
            && (ip_len >= hdr_len)
            && !(is_tcp && (l4_len < eip_pkg::TCP_HDR_LEN))
            && !(is_udp && (l4_len < eip_pkg::UDP_HDR_LEN));

        result = '0;
        if (ok)
        begin
            result.header_ok       = 1'b1;
            result.source_address  = hdr.src_addr;
            result.dest_address    = hdr.dst_addr;
            result.ip_protocol     = hdr.protocol;
            result.ip_total_length = hdr.total_length;
            if (is_tcp || is_udp)
            begin
                result.source_port = hdr.transport_src;
                result.dest_port   = hdr.transport_dst;
            end
            if (is_tcp)
            begin
                result.tcp_flag_bits = hdr.flags;
            end
        end
    end

endmodule

FILE: hdl/eth_ipv4_l4_header_parser.sv
// Top level of the Ethernet/IPv4/TCP-UDP header parser.
//
// The frame channel carries one captured frame byte per request, in wire
// order, with last_byte set on the final byte. The result channel carries
// one request per frame, issued for the byte flagged as last.
// Each byte is counted and captured by its offset in the cycle it is
// accepted; a byte may be accepted in every cycle without frame_stall.
// The result of a frame appears on the result channel in the cycle after
// its last byte is accepted, held in an output register.
// The byte counter saturates at 127; later bytes capture nothing.
// Reset clears the byte counter, the captured fields and the result valid.
// After each last byte the capture state returns to its reset value.
// While a result waits under result_stall, frame_stall is raised and no
// byte is taken; with no stall the block sustains one byte per cycle.
module eth_ipv4_l4_header_parser (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          frame_valid,
    output logic          frame_stall,
    input  eip_pkg::in_t  frame,
    output logic          result_valid,
    input  logic          result_stall,
    output eip_pkg::out_t result
);

    logic [6:0]    byte_index_reg;
    logic [6:0]    byte_index_next;
    eip_pkg::hdr_t hdr_reg;
    eip_pkg::hdr_t hdr_next;
    logic          result_valid_reg;
    eip_pkg::out_t result_reg;
    eip_pkg::out_t check_result;
    logic [7:0]    pos;
    logic [7:0]    l4_ofs;
    logic          accept;

    assign frame_stall  = result_valid_reg && result_stall;
    assign accept       = frame_valid && !frame_stall;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    always_comb
    begin
        hdr_next        = hdr_reg;
        byte_index_next = byte_index_reg;
        pos    = {1'b0, byte_index_reg};
        l4_ofs = eip_pkg::ETH_HDR_LEN + {2'b00, hdr_reg.version_ihl[3:0], 2'b00};
        if (byte_index_reg != eip_pkg::INDEX_MAX)
        begin
            if (byte_index_reg == eip_pkg::OFS_ETHERTYPE_HI
                || byte_index_reg == eip_pkg::OFS_ETHERTYPE_LO)
            begin
                hdr_next.ether_type = {hdr_reg.ether_type[7:0], frame.frame_byte};
            end
            else if (byte_index_reg == eip_pkg::OFS_VERSION_IHL)
            begin
                hdr_next.version_ihl = frame.frame_byte;
            end
            else if (byte_index_reg == eip_pkg::OFS_TOTLEN_HI
                || byte_index_reg == eip_pkg::OFS_TOTLEN_LO)
            begin
                hdr_next.total_length = {hdr_reg.total_length[7:0], frame.frame_byte};
            end
            else if (byte_index_reg == eip_pkg::OFS_PROTOCOL)
            begin
                hdr_next.protocol = frame.frame_byte;
            end
            else if (byte_index_reg >= eip_pkg::OFS_SRC_FIRST
                && byte_index_reg <= eip_pkg::OFS_SRC_LAST)
            begin
                hdr_next.src_addr = {hdr_reg.src_addr[23:0], frame.frame_byte};
            end
            else if (byte_index_reg >= eip_pkg::OFS_DST_FIRST
                && byte_index_reg <= eip_pkg::OFS_DST_LAST)
            begin
                hdr_next.dst_addr = {hdr_reg.dst_addr[23:0], frame.frame_byte};
            end

            if (byte_index_reg >= eip_pkg::OFS_TRANSPORT)
            begin
                if (pos == l4_ofs || pos == l4_ofs + 8'd1)
                begin
                    hdr_next.transport_src = {hdr_reg.transport_src[7:0], frame.frame_byte};
                end
                else if (pos == l4_ofs + 8'd2 || pos == l4_ofs + 8'd3)
                begin
                    hdr_next.transport_dst = {hdr_reg.transport_dst[7:0], frame.frame_byte};
                end
                else if (pos == l4_ofs + eip_pkg::OFS_TCP_FLAGS)
                begin
                    hdr_next.flags = frame.frame_byte;
                end
            end
            byte_index_next = byte_index_reg + 7'd1;
        end
    end

    eip_check u_check (
        .hdr       (hdr_next),
        .frame_len (byte_index_next),
        .result    (check_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_index_reg   <= '0;
            hdr_reg          <= '0;
            result_valid_reg <= 1'b0;
            result_reg       <= '0;
        end
        else
        begin
            if (accept)
            begin
                if (frame.last_byte)
                begin
                    byte_index_reg <= '0;
                    hdr_reg        <= '0;
                end
                else
                begin
                    byte_index_reg <= byte_index_next;
                    hdr_reg        <= hdr_next;
                end
            end

            if (accept && frame.last_byte)
            begin
                result_valid_reg <= 1'b1;
                result_reg       <= check_result;
            end
            else if (!result_stall)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

endmodule

FILE: hdl/eip_checker.sv
// Port-level assertions for the header parser and the bind that attaches them.
module eip_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          frame_valid,
    input logic          frame_stall,
    input eip_pkg::in_t  frame,
    input logic          result_valid,
    input logic          result_stall,
    input eip_pkg::out_t result
);

    // A held result keeps its value until it is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("stalled result changed or dropped");

    // Every accepted last byte yields a result in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        frame_valid && !frame_stall && frame.last_byte |=> result_valid)
        else $error("no result after last byte");

    // A failed frame reports all fields as zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.header_ok |-> result == '0)
        else $error("invalid result carries nonzero fields");

    // Ports are reported only for TCP and UDP.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.ip_protocol != eip_pkg::PROTO_TCP
        && result.ip_protocol != eip_pkg::PROTO_UDP
        |-> result.source_port == '0 && result.dest_port == '0)
        else $error("ports reported for a non-transport protocol");

    // Flags are reported only for TCP.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.ip_protocol != eip_pkg::PROTO_TCP
        |-> result.tcp_flag_bits == '0)
        else $error("flags reported for a non-TCP frame");

endmodule

bind eth_ipv4_l4_header_parser eip_checker u_eip_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .frame_valid  (frame_valid),
    .frame_stall  (frame_stall),
    .frame        (frame),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
);
